// ===== sv/fmofo_pkg.sv =====
// ----------------------------------------------------------------------------
// fmofo_pkg
// Shared types and constants for the FM operator with feedback.
// ----------------------------------------------------------------------------
package fmofo_pkg;

    localparam int TABLE_BITS_DEF = 12;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam int SINE_W = 16;

    typedef struct packed {
        logic        op;
        logic [31:0] pitch_increment;
        logic [12:0] fm_cv;
        logic [11:0] fm_knob;
        logic [12:0] pm_cv;
        logic [11:0] pm_knob;
        logic [12:0] fb_cv;
        logic [11:0] fb_knob;
        logic        sync_in;
        logic [11:0] table_index;
        logic [15:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_feedback;
        logic [15:0] out_fm_pm;
        logic        sync_out;
        logic        heartbeat;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // tick request taken: latch controls, apply sync
        logic load_wr;    // load request taken: write sine entry
        logic phase_add;
        logic rd_base;
        logic mul_fb;
        logic rd_a;
        logic rd_b;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/fmofo_ifs.sv =====
// ----------------------------------------------------------------------------
// fmofo_ifs
// Valid/ready channels for input requests and results.
// ----------------------------------------------------------------------------
interface fmofo_in_if;
    import fmofo_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fmofo_out_if;
    import fmofo_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fmofo_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmofo_ctrl
// Sequencer: steps one tick through phase update, three sine reads with the
// feedback multiply between the first two, and result hand-off. Load requests are taken without leaving idle.
// ----------------------------------------------------------------------------
module fmofo_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_op,
    output logic               o_in_ready,
    input  fmofo_pkg::t_dp_sts i_sts,
    output fmofo_pkg::t_dp_cmd o_cmd
);
    import fmofo_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PHASE = 7'b0000010,
        S_RD_I  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_RD_A  = 7'b0010000,
        S_RD_B  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_PHASE;
                    end
                end
            end
            S_PHASE: begin
                o_cmd.phase_add = 1'b1;
                n_state         = S_RD_I;
            end
            S_RD_I: begin
                o_cmd.rd_base = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_fb = 1'b1;
                n_state      = S_RD_A;
            end
            S_RD_A: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/fmofo_dp.sv =====
// ----------------------------------------------------------------------------
// fmofo_dp
// Datapath: phase accumulator, sync edge logic, modulation multipliers,
// single-port sine memory and the result register.
// ----------------------------------------------------------------------------
module fmofo_dp #(
    parameter int TABLE_BITS = fmofo_pkg::TABLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmofo_pkg::t_in_item  i_item,
    input  fmofo_pkg::t_dp_cmd   i_cmd,
    output fmofo_pkg::t_dp_sts   o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fmofo_pkg::t_out_item o_item
);
    import fmofo_pkg::*;

    localparam int DEPTH = 2 ** TABLE_BITS;
    localparam logic [TABLE_BITS-1:0] HALF    = TABLE_BITS'(DEPTH / 2);
    localparam logic [TABLE_BITS-1:0] QUARTER = TABLE_BITS'(DEPTH / 4);

    logic [SINE_W-1:0] mem [0:DEPTH-1];

    logic [31:0]               r_phase;
    logic [31:0]               n_phase;
    logic                      r_last_sync;
    logic                      n_last_sync;
    logic [31:0]               r_pitch;
    logic signed [26:0]        r_fm_prod;
    logic signed [26:0]        r_pm_prod;
    logic [12:0]               r_fb_gain;
    logic signed [30:0]        r_fb_prod;
    logic [SINE_W-1:0]         r_rd;
    logic [SINE_W-1:0]         r_sine_a;
    logic [TABLE_BITS-1:0]     r_a;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic signed [13:0]        fm_off;
    logic signed [13:0]        pm_off;
    logic signed [26:0]        fm_prod_c;
    logic signed [26:0]        pm_prod_c;
    logic [24:0]               fb_gain_c;
    logic signed [16:0]        sine_off;
    logic signed [30:0]        fb_prod_c;
    logic [31:0]               fm_term;
    logic [TABLE_BITS-1:0]     idx;
    logic [TABLE_BITS-1:0]     a_c;
    logic [TABLE_BITS-1:0]     b_c;
    logic [TABLE_BITS-1:0]     rd_addr;
    logic [TABLE_BITS-1:0]     wr_addr;
    logic                      rd_en;

    // FM and PM control values are offset binary around 2048
    assign fm_off    = $signed({1'b0, i_item.fm_cv}) - 14'sd2048;
    assign pm_off    = $signed({1'b0, i_item.pm_cv}) - 14'sd2048;
    assign fm_prod_c = fm_off * $signed({1'b0, i_item.fm_knob});
    assign pm_prod_c = pm_off * $signed({1'b0, i_item.pm_knob});
    assign fb_gain_c = i_item.fb_knob * i_item.fb_cv;

    assign sine_off  = $signed({1'b0, r_rd}) - 17'sd32767;
    assign fb_prod_c = sine_off * $signed({1'b0, r_fb_gain});

    // FM term << 5, sign carried into bit 31
    assign fm_term = {r_fm_prod, 5'b0};
    assign idx     = r_phase[31 -: TABLE_BITS];

    // low bits of an arithmetic shift are a floor shift taken mod table size
    assign a_c = idx + r_fb_prod[12 +: TABLE_BITS];
    assign b_c = r_a + r_pm_prod[10 +: TABLE_BITS];

    assign wr_addr = TABLE_BITS'(i_item.table_index);
    assign rd_en   = i_cmd.rd_base || i_cmd.rd_a || i_cmd.rd_b;

    always_comb begin
        if (i_cmd.rd_base) begin
            rd_addr = idx;
        end else if (i_cmd.rd_a) begin
            rd_addr = a_c + HALF;
        end else begin
            rd_addr = b_c + HALF;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_last_sync = r_last_sync;
        if (i_cmd.capture) begin
            if (!i_item.sync_in) begin
                if (r_last_sync) begin
                    n_phase     = '0;
                    n_last_sync = 1'b0;
                end
            end else begin
                n_last_sync = 1'b1;
            end
        end else if (i_cmd.phase_add) begin
            n_phase = r_phase + r_pitch + fm_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            mem[wr_addr] <= i_item.table_value;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_last_sync <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_last_sync <= n_last_sync;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pitch   <= i_item.pitch_increment;
            r_fm_prod <= fm_prod_c;
            r_pm_prod <= pm_prod_c;
            r_fb_gain <= fb_gain_c[24:12];
        end
        if (i_cmd.mul_fb) begin
            r_fb_prod <= fb_prod_c;
        end
        if (i_cmd.rd_a) begin
            r_a <= a_c;
        end
        if (i_cmd.rd_b) begin
            r_sine_a <= r_rd;
        end
        if (i_cmd.out_load) begin
            r_out.out_feedback <= r_sine_a;
            r_out.out_fm_pm    <= r_rd;
            r_out.sync_out     <= (r_a > HALF);
            r_out.heartbeat    <= (idx >= QUARTER);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_item         = r_out;

endmodule

// ===== sv/fm_operator_feedback_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// fm_operator_feedback_oscillator_top
// FM operator with self-feedback, phase modulation, hard sync and a
// loadable sine table. A sample tick steps from acceptance through the phase
// update, the three dependent reads of the single-port sine memory (base
// phase, feedback phase, modulated phase) with the feedback multiply between
// the first two, and the result hand-off into the output register, which
// waits while an earlier result still sits there. The next request is
// accepted in the cycle after that hand-off, so a new tick is not taken
// before the previous one has been handed off.
// A load request writes one table entry and gives no result.
// The sine memory has no reset and no clearing pass: load every entry that
// ticks can reach before sending ticks. The result register lets a new
// request enter while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module fm_operator_feedback_oscillator_top #(
    parameter int TABLE_BITS = fmofo_pkg::TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fmofo_in_if.sink    i_in,
    fmofo_out_if.source o_out
);
    import fmofo_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    fmofo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.data.op),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fmofo_dp #(
        .TABLE_BITS (TABLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_item      (o_out.data)
    );

endmodule

// ===== sv/fmofo_checker.sv =====
// ----------------------------------------------------------------------------
// fmofo_checker
// Port-level checks for the FM operator, bound to the top level.
// ----------------------------------------------------------------------------
module fmofo_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_in_op,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input fmofo_pkg::t_out_item i_out_data
);
    import fmofo_pkg::*;

    logic tick_acc;
    logic load_acc;

    assign tick_acc = i_in_valid && i_in_ready && (i_in_op == OP_TICK);
    assign load_acc = i_in_valid && i_in_ready && (i_in_op == OP_LOAD);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> !i_in_ready)
        else $error("ready right after a tick request");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_acc && !i_out_valid) |=> !i_out_valid)
        else $error("load request produced a result");

    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind fm_operator_feedback_oscillator_top fmofo_checker u_fmofo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.data.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
